/* src/bflr_pkg.sv */
// ----------------------------------------------------------------------------
// Box filter letterbox resize package
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bflr_pkg;

  localparam int MAX_SRC_DIM = 256;
  localparam int SRC_PIXELS  = 65536;
  localparam int OUT_MAX     = 256;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_OUT_SIZE   = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_GEOM,
    OP_BOX_START,
    OP_ACCUM,
    OP_PAD,
    OP_DONE,
    OP_TAKE
  } op_t;

  typedef enum logic [2:0] {
    DS_DRAW_W,
    DS_DRAW_H,
    DS_SY0,
    DS_SY1,
    DS_SX0,
    DS_SX1,
    DS_MEAN
  } div_sel_t;

  typedef struct packed {
    op_t      op;
    div_sel_t sel;
    logic     last_col;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic outside;
    logic row_end;
    logic box_end;
  } status_t;

endpackage

/* src/box_filter_letterbox_resize.sv */
// Timing: a load is written at its transfer; a padding request has its result
// ready after the two draw-size divisions; a drawn pixel takes ten serial
// divisions plus a read and an accumulate step per source sample of its box.
// One item is in work at a time and the next transfer waits until the result is
// taken; the serial divider and the single store read port set the rate.
// Reset clears control state and loads the register defaults; the store is kept.
// ----------------------------------------------------------------------------
// Box filter letterbox resize
// Area-average downscale of a stored RGBA8 image into a centered square.
// ----------------------------------------------------------------------------
module box_filter_letterbox_resize
  import bflr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // src_index, in_red, in_green, in_blue, in_alpha, dest_x, dest_y
  input  logic [63:0] s_axis_tdata,
  // action
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] m_axis_tdata,
  // inside_drawn
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [8:0] src_width, src_height, out_size;
  logic busy, in_fire, res_valid;
  cmd_t cmd;
  status_t status;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= 9'd256;
      src_height <= 9'd256;
      out_size <= 9'd32;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SRC_WIDTH) src_width <= cfg_data;
      if (cfg_index == REG_SRC_HEIGHT) src_height <= cfg_data;
      if (cfg_index == REG_OUT_SIZE) out_size <= cfg_data;
    end
  end

  bflr_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_action(s_axis_tuser), .status, .cmd, .busy,
    .res_valid, .res_taken(m_axis_tvalid && m_axis_tready)
  );

  bflr_datapath u_dp (
    .clk, .rst, .cmd, .status, .src_width, .src_height, .out_size,
    .src_index(s_axis_tdata[15:0]), .in_pixel(s_axis_tdata[47:16]),
    .dest_x(s_axis_tdata[55:48]), .dest_y(s_axis_tdata[63:56]),
    .out_pixel(m_axis_tdata), .out_inside(m_axis_tuser)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("padding result not zero");
`endif

endmodule

/* src/bflr_datapath.sv */
// ----------------------------------------------------------------------------
// Box filter letterbox resize datapath
// Pixel store, geometry registers, shared serial divider and box accumulators.
// ----------------------------------------------------------------------------
module bflr_datapath
  import bflr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [8:0]  src_width,
  input  logic [8:0]  src_height,
  input  logic [8:0]  out_size,
  input  logic [15:0] src_index,
  input  logic [31:0] in_pixel,
  input  logic [7:0]  dest_x,
  input  logic [7:0]  dest_y,
  output logic [31:0] out_pixel,
  output logic        out_inside
);

  localparam int AW = $clog2(SRC_PIXELS);
  localparam int DW = $clog2(MAX_SRC_DIM + 1);
  localparam int NW = DW + 10;
  localparam int SW = 8 + 2 * DW;
  localparam int QW = (NW > SW) ? NW : SW;
  localparam int CW = $clog2(QW + 1);

  logic [31:0] store [SRC_PIXELS];
  logic [31:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [DW-1:0] sw, sh, mx;
  logic [8:0] size;
  logic [8:0] draw_w, draw_h, off_x, off_y, rx, ry;
  logic [DW-1:0] sy0, sy1, sx0, sx1, sy, sx;
  logic [SW-1:0] acc [4];
  logic [2*DW-1:0] samples;
  logic [1:0] ch;
  logic [QW-1:0] num, quo;
  logic [QW:0] rem;
  logic [QW-1:0] den;
  logic [CW-1:0] cnt;
  logic [AW-1:0] row_base;
  logic [7:0] dx_q, dy_q;
  logic div_done;

  logic [QW:0] rem_sh;
  assign rem_sh = {rem[QW-1:0], num[QW-1]};

  function automatic logic [DW-1:0] clampd(input logic [8:0] v);
    if (v == 9'd0) return DW'(1);
    if (32'(v) > MAX_SRC_DIM) return DW'(MAX_SRC_DIM);
    return DW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) store[src_index[AW-1:0]] <= in_pixel;
    rd_data <= store[rd_addr];
  end

  assign rd_addr = AW'(row_base + AW'(sx));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      unique case (cmd.op)
        OP_SETUP: begin
          sw <= clampd(src_width);
          sh <= clampd(src_height);
          size <= (out_size == 9'd0) ? 9'd1 :
                  (32'(out_size) > OUT_MAX) ? 9'(OUT_MAX) : out_size;
        end
        OP_DIV_START: begin
          if (cmd.sel == DS_DRAW_W || cmd.sel == DS_DRAW_H) begin
            mx <= (sw > sh) ? sw : sh;
          end
          unique case (cmd.sel)
            DS_DRAW_W: begin
              num <= QW'({sw, 1'b0}) * QW'(size) + QW'((sw > sh) ? sw : sh);
              den <= QW'({((sw > sh) ? sw : sh), 1'b0});
            end
            DS_DRAW_H: begin
              num <= QW'({sh, 1'b0}) * QW'(size) + QW'(mx);
              den <= QW'({mx, 1'b0});
            end
            DS_SY0: begin num <= QW'(ry) * QW'(sh); den <= QW'(draw_h); end
            DS_SY1: begin num <= QW'(ry + 9'd1) * QW'(sh); den <= QW'(draw_h); end
            DS_SX0: begin num <= QW'(rx) * QW'(sw); den <= QW'(draw_w); end
            DS_SX1: begin num <= QW'(rx + 9'd1) * QW'(sw); den <= QW'(draw_w); end
            DS_MEAN: begin num <= QW'(acc[ch]); den <= QW'(samples); end
            default: ;
          endcase
          rem <= '0;
          cnt <= CW'(QW);
        end
        OP_DIV_STEP: begin
          num <= {num[QW-2:0], 1'b0};
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            quo <= {quo[QW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[QW-2:0], 1'b0};
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) div_done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic [8:0] q9;
  assign q9 = (quo[QW-1:9] != '0) ? 9'h1ff : quo[8:0];

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.sel)
        DS_DRAW_W: draw_w <= (quo == '0) ? 9'd1 : q9;
        DS_DRAW_H: draw_h <= (quo == '0) ? 9'd1 : q9;
        DS_SY0: sy0 <= DW'(quo);
        DS_SY1: sy1 <= DW'(quo);
        DS_SX0: sx0 <= DW'(quo);
        DS_SX1: sx1 <= DW'(quo);
        DS_MEAN: begin
          out_pixel[8*ch +: 8] <= quo[7:0];
          ch <= ch + 2'd1;
        end
        default: ;
      endcase
    end
    unique case (cmd.op)
      OP_TAKE: begin
        dx_q <= dest_x;
        dy_q <= dest_y;
      end
      OP_GEOM: begin
        off_x <= (size - draw_w) >> 1;
        off_y <= (size - draw_h) >> 1;
        rx <= 9'(dx_q) - ((size - draw_w) >> 1);
        ry <= 9'(dy_q) - ((size - draw_h) >> 1);
        ch <= 2'd0;
      end
      OP_BOX_START: begin
        if (sy1 <= sy0) sy1 <= sy0 + DW'(1);
        if (sx1 <= sx0) sx1 <= sx0 + DW'(1);
        sy <= sy0;
        sx <= sx0;
        row_base <= AW'(sy0) * AW'(sw);
        samples <= '0;
        for (int c = 0; c < 4; c++) acc[c] <= '0;
        out_inside <= 1'b1;
      end
      OP_ACCUM: begin
        if (cmd.last_col) begin
          for (int c = 0; c < 4; c++) acc[c] <= acc[c] + SW'(rd_data[8*c +: 8]);
          samples <= samples + (2*DW)'(1);
        end
        if (status.row_end) begin
          sx <= sx0;
          sy <= sy + DW'(1);
          row_base <= row_base + AW'(sw);
        end else begin
          sx <= sx + DW'(1);
        end
      end
      OP_PAD: begin
        out_pixel <= '0;
        out_inside <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.div_done = div_done;
    status.outside = ({1'b0, dx_q} >= size) || ({1'b0, dy_q} >= size) ||
                     ({1'b0, dx_q} < off_x) || ({1'b0, dx_q} >= off_x + draw_w) ||
                     ({1'b0, dy_q} < off_y) || ({1'b0, dy_q} >= off_y + draw_h);
    status.row_end = (sx + DW'(1) >= sx1);
    status.box_end = (sx + DW'(1) >= sx1) && (sy + DW'(1) >= sy1);
  end

endmodule

/* src/bflr_ctrl.sv */
// ----------------------------------------------------------------------------
// Box filter letterbox resize controller
// Sequences loads, geometry divisions, box walk and channel means.
// ----------------------------------------------------------------------------
module bflr_ctrl
  import bflr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic    in_action,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    res_valid,
  input  logic    res_taken
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_DSTART, S_DSTEP, S_GEOM, S_BOX, S_READ, S_ACC, S_LAST,
    S_PAD, S_OUT
  } state_t;

  state_t   state;
  div_sel_t sel;
  logic [1:0] mean_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= DS_DRAW_W;
      res_valid <= 1'b0;
    end else begin
      if (res_taken) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_fire && in_action) state <= S_SETUP;
        S_SETUP: begin sel <= DS_DRAW_W; state <= S_DSTART; end
        S_DSTART: state <= S_DSTEP;
        S_DSTEP: if (status.div_done) begin
          unique case (sel)
            DS_DRAW_W: begin sel <= DS_DRAW_H; state <= S_DSTART; end
            DS_DRAW_H: state <= S_GEOM;
            DS_SY0: begin sel <= DS_SY1; state <= S_DSTART; end
            DS_SY1: begin sel <= DS_SX0; state <= S_DSTART; end
            DS_SX0: begin sel <= DS_SX1; state <= S_DSTART; end
            DS_SX1: state <= S_BOX;
            DS_MEAN: state <= (mean_cnt == 2'd3) ? S_LAST : S_DSTART;
            default: state <= S_IDLE;
          endcase
        end
        S_GEOM: state <= S_PAD;
        S_PAD: if (status.outside) state <= S_OUT;
               else begin sel <= DS_SY0; state <= S_DSTART; end
        S_BOX: state <= S_READ;
        S_READ: state <= S_ACC;
        S_ACC: if (status.box_end) state <= S_ACC; else state <= S_READ;
        S_LAST: state <= S_IDLE;
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (state == S_ACC && status.box_end) begin
        sel <= DS_MEAN;
        state <= S_DSTART;
      end
      if (state == S_LAST) state <= S_IDLE;
      if (state == S_OUT || (state == S_LAST)) res_valid <= 1'b1;
    end
  end

  // The four channel means run back to back; the controller counts them.
  always_ff @(posedge clk) begin
    if (rst || state == S_BOX) mean_cnt <= 2'd0;
    else if (state == S_DSTEP && status.div_done && sel == DS_MEAN)
      mean_cnt <= mean_cnt + 2'd1;
  end

  state_t st_eff;
  always_comb begin
    st_eff = state;
    cmd.op = OP_NONE;
    cmd.sel = sel;
    cmd.last_col = 1'b0;
    unique case (state)
      S_IDLE: if (in_fire) cmd.op = in_action ? OP_TAKE : OP_LOAD;
      S_SETUP: cmd.op = OP_SETUP;
      S_DSTART: cmd.op = OP_DIV_START;
      S_DSTEP: cmd.op = OP_DIV_STEP;
      S_GEOM: cmd.op = OP_GEOM;
      S_PAD: if (status.outside) cmd.op = OP_PAD;
      S_BOX: cmd.op = OP_BOX_START;
      S_ACC: begin cmd.op = OP_ACCUM; cmd.last_col = 1'b1; end
      default: ;
    endcase
    busy = (st_eff != S_IDLE) || res_valid;
  end

endmodule

/* sim/box_filter_letterbox_resize_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box filter letterbox resize checker
// Watches the pixel, result and register channels, keeps its own copy of the
// pixel store and registers, predicts each requested pixel and compares it.
// ----------------------------------------------------------------------------
module box_filter_letterbox_resize_checker
  import bflr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic       drawn;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic [31:0] pixel_mem [0:65535];
  logic [8:0]  width_reg, height_reg, size_reg;
  pixel_t      pixel_q [$];

  function automatic int unsigned clamp_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic int unsigned fit_len(int unsigned d, int unsigned s, int unsigned m);
    int unsigned r;
    r = (2 * d * s + m) / (2 * m);
    return (r < 1) ? 1 : r;
  endfunction

  function automatic pixel_t average_pixel(logic [7:0] dx, logic [7:0] dy);
    int unsigned sw, sh, sz, m, dw, dh, ox, oy, x, y;
    int unsigned y0, y1, x0, x1, n;
    int unsigned acc [4];
    logic [31:0] w;
    pixel_t p;
    sw = clamp_dim(width_reg);
    sh = clamp_dim(height_reg);
    sz = clamp_dim(size_reg);
    m = (sw > sh) ? sw : sh;
    dw = fit_len(sw, sz, m);
    dh = fit_len(sh, sz, m);
    ox = (sz - dw) / 2;
    oy = (sz - dh) / 2;
    p = '0;
    if (dx >= sz || dy >= sz) return p;
    if (dx < ox || dx >= ox + dw || dy < oy || dy >= oy + dh) return p;
    x = dx - ox;
    y = dy - oy;
    y0 = y * sh / dh;
    y1 = (y + 1) * sh / dh;
    x0 = x * sw / dw;
    x1 = (x + 1) * sw / dw;
    if (y1 < y0 + 1) y1 = y0 + 1;
    if (x1 < x0 + 1) x1 = x0 + 1;
    acc = '{0, 0, 0, 0};
    n = 0;
    for (int unsigned sy = y0; sy < y1; sy++) begin
      for (int unsigned sx = x0; sx < x1; sx++) begin
        w = pixel_mem[(sy * sw + sx) % 65536];
        for (int c = 0; c < 4; c++) acc[c] += w[8*c +: 8];
        n++;
      end
    end
    p.red = 8'(acc[0] / n);
    p.green = 8'(acc[1] / n);
    p.blue = 8'(acc[2] / n);
    p.alpha = 8'(acc[3] / n);
    p.drawn = 1'b1;
    return p;
  endfunction

  assign pending = pixel_q.size();

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst) begin
      width_reg <= 9'd256;
      height_reg <= 9'd256;
      size_reg <= 9'd32;
      pixel_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_WIDTH: width_reg <= cfg_data;
          REG_SRC_HEIGHT: height_reg <= cfg_data;
          REG_OUT_SIZE: size_reg <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (!s_axis_tuser)
          pixel_mem[s_axis_tdata[15:0]] = s_axis_tdata[47:16];
        else
          pixel_q.insert(pixel_q.size(),
                         average_pixel(s_axis_tdata[55:48], s_axis_tdata[63:56]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (pixel_q.size() == 0) begin
          $error("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = pixel_q.pop_front();
          if (got != want) fail_count <= fail_count + 1;
          if (got.red != want.red)
            $error("out_red expected %0d got %0d", want.red, got.red);
          if (got.green != want.green)
            $error("out_green expected %0d got %0d", want.green, got.green);
          if (got.blue != want.blue)
            $error("out_blue expected %0d got %0d", want.blue, got.blue);
          if (got.alpha != want.alpha)
            $error("out_alpha expected %0d got %0d", want.alpha, got.alpha);
          if (got.drawn != want.drawn)
            $error("inside_drawn expected %0d got %0d", want.drawn, got.drawn);
        end
      end
    end
  end

endmodule

/* sim/box_filter_letterbox_resize_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box filter letterbox resize testbench
// Loads small source images under several register settings, requests output
// pixels in and around the drawn area, and checks each against the checker.
// ----------------------------------------------------------------------------
module box_filter_letterbox_resize_tb
  import bflr_pkg::*;
();

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;
  int          fail_count;
  int          pending;
  int          send_idle;
  int          recv_idle;
  int          size_now;

  box_filter_letterbox_resize dut (.*);
  box_filter_letterbox_resize_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("box_filter_letterbox_resize_tb: errors");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Valid stays high after the transfer so that the next write can follow at
  // once; the caller drops it when the run of writes ends.
  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Valid is dropped only in idle cycles and by drain, so items can follow
  // back to back.
  task automatic send_item(logic action, logic [63:0] data);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tuser <= action;
    s_axis_tdata <= data;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic load_pixel(int unsigned pos, logic [31:0] rgba);
    send_item(1'b0, {16'd0, rgba, pos[15:0]});
  endtask

  task automatic ask_pixel(logic [7:0] dx, logic [7:0] dy);
    send_item(1'b1, {dy, dx, $urandom(), 16'($urandom())});
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (800) @(negedge clk);
  endtask

  // Registers change only here, with nothing outstanding. The whole source
  // image is loaded afterwards so that no request reads an unwritten entry.
  task automatic new_image(int unsigned w, int unsigned h, int unsigned s, bit extremes);
    drain();
    size_now = s;
    write_reg(REG_SRC_WIDTH, 9'(w));
    write_reg(REG_SRC_HEIGHT, 9'(h));
    write_reg(REG_OUT_SIZE, 9'(s));
    write_reg(REG_UNUSED, 9'($urandom()));
    cfg_valid <= 1'b0;
    for (int unsigned i = 0; i < w * h; i++) begin
      if (extremes) load_pixel(i, (i % 2) ? 32'hFFFF_FFFF : 32'h0);
      else load_pixel(i, $urandom());
    end
  endtask

  task automatic random_requests(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        ask_pixel(8'($urandom()), 8'($urandom()));
      else
        ask_pixel(8'($urandom_range(size_now - 1)), 8'($urandom_range(size_now - 1)));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 23;
    recv_idle = 45;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    new_image(4, 2, 8, 1'b1);
    ask_pixel(8'd0, 8'd0);
    ask_pixel(8'd0, 8'd2);
    ask_pixel(8'd7, 8'd5);
    ask_pixel(8'd3, 8'd3);
    ask_pixel(8'd8, 8'd3);
    ask_pixel(8'd255, 8'd255);
    new_image(1, 1, 256, 1'b0);
    ask_pixel(8'd0, 8'd0);
    ask_pixel(8'd255, 8'd255);
    ask_pixel(8'd128, 8'd128);
    new_image(16, 1, 1, 1'b0);
    ask_pixel(8'd0, 8'd0);
    ask_pixel(8'd1, 8'd0);
    new_image(2, 16, 3, 1'b0);
    ask_pixel(8'd1, 8'd1);
    ask_pixel(8'd0, 8'd2);
    ask_pixel(8'd2, 8'd2);
    new_image(1, 1, 0, 1'b0);
    ask_pixel(8'd0, 8'd0);
    ask_pixel(8'd1, 8'd0);
    // A 256-wide row exercises the top of the width range and the high index bits.
    new_image(256, 1, 5, 1'b0);
    load_pixel(32'hFFFF, 32'hFFFF_FFFF);
    ask_pixel(8'd2, 8'd2);
    ask_pixel(8'd4, 8'd2);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 23 : (phase == 1) ? 45 : 0;
      recv_idle = (phase == 0) ? 45 : (phase == 1) ? 23 : 0;
      for (int k = 0; k < 4; k++) begin
        new_image($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 24), 1'b0);
        random_requests(80);
      end
    end
    drain();
    if (fail_count == 0)
      $display("box_filter_letterbox_resize_tb: clean");
    else
      $display("box_filter_letterbox_resize_tb: errors");
    $finish;
  end

endmodule
